// File: design/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// types and codes shared by the first-fit allocator front, queue and back
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned HeapWidth = 17;
  localparam int unsigned AddrWidth = 19;
  localparam int unsigned SizeWidth = 20;

  // bytes per heap word, a power of two
  localparam int unsigned WordBytes = 8;

  typedef enum logic [1:0] {
    KIND_FREE = 2'd0,
    KIND_USED = 2'd1,
    KIND_END  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FIT       = 2'd1,
    ST_INVALID_FREE = 2'd2,
    ST_TABLE_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef struct packed {
    logic                 req_type;
    logic [SizeWidth-1:0] size_bytes;
    logic [AddrWidth-1:0] block_address;
  } req_t;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
    logic [1:0]           status;
  } rsp_t;

  // classified command between front and back
  typedef struct packed {
    logic                 is_free;
    logic                 bad_align;
    logic [HeapWidth-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic [HeapWidth-1:0] word;
    logic [1:0]           kind;
  } entry_t;

endpackage

// File: design/first_fit_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_unit
// first-fit heap allocator with coalescing over a fixed word region
// ----------------------------------------------------------------------------
//  channel   signals                      direction  beat taken when
//  request   start_i, req_i               in         start_i && !busy_o
//  result    done_o, rsp_o                out        done_o (one cycle)
//  config    cfg_we_i, cfg_wdata_i        in         cfg_we_i
//
//  a request scans the table entry by entry and moves entries one at a time
//  for an insert or erase; the boundary ram gives one registered read a cycle
//  reset empties the table; the first allocate builds it from heap_words
//  busy_o is high while the two-deep command queue is full
//  results cannot be held off: done_o marks each one for a single cycle
module first_fit_block_allocator_unit
  import ffba_pkg::*;
#(
  parameter int unsigned MaxEntries = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  req_t                 req_i,
  output logic                 done_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [HeapWidth-1:0] cfg_wdata_i
);

  logic [HeapWidth-1:0] heap_q;
  cmd_t                 cmd_in, cmd_out;
  logic                 full, qvalid, pop, push;

  // register holds low 17 bits; values above 65536 saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= HeapWidth'(512);
    end else if (cfg_we_i) begin
      heap_q <= cfg_wdata_i[HeapWidth-1] ? HeapWidth'(65536) : cfg_wdata_i;
    end
  end

  assign busy_o = full;
  assign push   = start_i && !full;

  ffba_front u_front (
    .req_i (req_i),
    .cmd_o (cmd_in)
  );

  ffba_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .data_o  (cmd_out)
  );

  ffba_back #(.MaxEntries(MaxEntries)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .heap_words_i (heap_q),
    .valid_i      (qvalid),
    .cmd_i        (cmd_out),
    .pop_o        (pop),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

`ifndef SYNTH
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> qvalid) else $error("busy with empty queue");
  a_heap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q <= HeapWidth'(65536)) else $error("heap size out of range");
  a_status_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.address == '0)
    else $error("failed request with address");
`endif

endmodule

// File: design/ffba_ram.sv
// ----------------------------------------------------------------------------
// ffba_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: design/ffba_front.sv
// ----------------------------------------------------------------------------
// ffba_front
// takes a request and classifies it into a word-count or word-offset command
// ----------------------------------------------------------------------------
module ffba_front
  import ffba_pkg::*;
(
  input  req_t req_i,
  output cmd_t cmd_o
);

  localparam int unsigned Sh = $clog2(WordBytes);

  logic [SizeWidth:0] need_w;
  logic [AddrWidth-1:0] off_w;
  logic [AddrWidth-1:0] rem_w;

  // word counts by shift and mask, the word size being a power of two
  always_comb begin
    need_w = (req_i.size_bytes == '0) ? (SizeWidth+1)'(1)
           : (SizeWidth+1)'(((req_i.size_bytes - 1'b1) >> Sh)) + 1'b1;
    off_w  = req_i.block_address >> Sh;
    rem_w  = req_i.block_address & AddrWidth'(WordBytes - 1);
    cmd_o.is_free   = (req_i.req_type == REQ_FREE);
    cmd_o.bad_align = (rem_w != '0);
    if (req_i.req_type == REQ_FREE) begin
      cmd_o.key = HeapWidth'(off_w);
    end else begin
      // sizes above 65536 words can never fit the heap of at most 65536 words
      cmd_o.key = (need_w > (SizeWidth+1)'(65536)) ? '1 : HeapWidth'(need_w);
    end
  end

endmodule

// File: design/ffba_queue.sv
// ----------------------------------------------------------------------------
// ffba_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ffba_queue
  import ffba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  cmd_t       buf_q [2];
  logic       rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = buf_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    rd_d  = rd_q ^ pop_i;
    wr_d  = wr_q ^ push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule

// File: design/ffba_back.sv
// ----------------------------------------------------------------------------
// ffba_back
// sequencer that scans and edits the boundary table in ram
// ----------------------------------------------------------------------------
module ffba_back
  import ffba_pkg::*;
#(
  parameter int unsigned MaxEntries = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [HeapWidth-1:0] heap_words_i,
  input  logic                 valid_i,
  input  cmd_t                 cmd_i,
  output logic                 pop_o,
  output logic                 done_o,
  output rsp_t                 rsp_o
);

  localparam int unsigned IdxW = $clog2(MaxEntries);
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;  // issue read of idx_q
  localparam logic [3:0] S_CHK   = 4'd2;  // examine entry idx_q, prev_q holds idx_q-1
  localparam logic [3:0] S_SHR   = 4'd3;  // shift up: read k-1
  localparam logic [3:0] S_SHW   = 4'd4;  // shift up: write k
  localparam logic [3:0] S_SLR   = 4'd5;  // shift down: read k+1
  localparam logic [3:0] S_SLW   = 4'd6;  // shift down: write k
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_BUILD = 4'd8;

  logic [3:0]           st_q, st_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      idx_q, idx_d;   // entry being read
  logic [CntW-1:0]      k_q, k_d;       // shift pointer
  logic [CntW-1:0]      stop_q, stop_d; // shift end
  logic [CntW-1:0]      hit_q, hit_d;   // matched entry index
  entry_t               prev_q, prev_d; // entry idx-1
  entry_t               pp_q, pp_d;     // entry idx-2
  entry_t               ins_q, ins_d;   // entry to insert after shift
  logic [1:0]           phase_q, phase_d;
  cmd_t                 cmd_q, cmd_d;
  rsp_t                 rsp_q, rsp_d;
  logic                 done_q, done_d;
  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  entry_t               wdata, rdata;
  logic [HeapWidth-1:0] len;
  logic [HeapWidth-1:0] hw_sat;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_MERGE_PREV = 2'd1;

  ffba_ram #(.Width($bits(entry_t)), .Depth(MaxEntries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pop_o  = (st_q == S_IDLE) && valid_i;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign len    = rdata.word - prev_q.word;
  assign hw_sat = (heap_words_i == '0) ? HeapWidth'(1) : heap_words_i;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; idx_d = idx_q; k_d = k_q; stop_d = stop_q;
    hit_d = hit_q; prev_d = prev_q; pp_d = pp_q; ins_d = ins_q;
    phase_d = phase_q; cmd_d = cmd_q; rsp_d = rsp_q; done_d = 1'b0;
    we = 1'b0; waddr = idx_q[IdxW-1:0]; wdata = prev_q;
    raddr = idx_q[IdxW-1:0];
    unique case (st_q)
      S_IDLE: begin
        if (valid_i) begin
          cmd_d = cmd_i;
          rsp_d = '{address: '0, status: ST_OK};
          idx_d = '0;
          if (cmd_i.is_free && (cnt_q == '0 || cmd_i.bad_align)) begin
            rsp_d.status = ST_INVALID_FREE;
            st_d = S_FIN;
          end else if (cnt_q == '0) begin
            st_d = S_BUILD;
          end else begin
            st_d = S_RD;
          end
        end
      end
      S_BUILD: begin
        // free at 0 then end at heap size, two writes
        we = 1'b1;
        if (idx_q == '0) begin
          waddr = '0; wdata = '{word: '0, kind: KIND_FREE};
          idx_d = CntW'(1);
        end else begin
          waddr = IdxW'(1); wdata = '{word: hw_sat, kind: KIND_END};
          cnt_d = CntW'(2); idx_d = '0; st_d = S_RD;
        end
      end
      S_RD: begin
        raddr = idx_q[IdxW-1:0];
        pp_d = prev_q;
        st_d = S_CHK;
      end
      S_CHK: begin
        // rdata is entry idx_q, prev_q is idx_q-1, pp_q is idx_q-2
        if (!cmd_q.is_free) begin
          if (idx_q != '0 && prev_q.kind == KIND_FREE && len >= cmd_q.key) begin
            hit_d = idx_q - 1'b1;
            rsp_d.address = AddrWidth'(prev_q.word * WordBytes);
            if (len > cmd_q.key) begin
              if (cnt_q >= CntW'(MaxEntries)) begin
                rsp_d = '{address: '0, status: ST_TABLE_FULL};
                st_d = S_FIN;
              end else begin
                // mark used, then open a slot at idx_q
                we = 1'b1; waddr = hit_d[IdxW-1:0];
                wdata = '{word: prev_q.word, kind: KIND_USED};
                ins_d = '{word: prev_q.word + cmd_q.key, kind: KIND_FREE};
                k_d = cnt_q; stop_d = idx_q; st_d = S_SHR;
              end
            end else begin
              we = 1'b1; waddr = hit_d[IdxW-1:0];
              wdata = '{word: prev_q.word, kind: KIND_USED};
              st_d = S_FIN;
            end
          end else if (idx_q + 1'b1 >= cnt_q) begin
            rsp_d = '{address: '0, status: ST_NO_FIT};
            st_d = S_FIN;
          end else begin
            prev_d = rdata; idx_d = idx_q + 1'b1; raddr = idx_d[IdxW-1:0];
            pp_d = prev_q; st_d = S_CHK;
          end
        end else begin
          // free: examine entry idx_q-1 once its successor is read
          if (idx_q != '0 && {2'b0, prev_q.word} == {2'b0, cmd_q.key} &&
              prev_q.kind != KIND_NONE) begin
            if (prev_q.kind != KIND_USED) begin
              rsp_d.status = ST_INVALID_FREE; st_d = S_FIN;
            end else begin
              hit_d = idx_q - 1'b1;
              we = 1'b1; waddr = hit_d[IdxW-1:0];
              wdata = '{word: prev_q.word, kind: KIND_FREE};
              if (idx_q < cnt_q && rdata.kind == KIND_FREE) begin
                // erase successor, then check predecessor
                k_d = idx_q; stop_d = cnt_q - 1'b1; st_d = S_SLR;
                cnt_d = cnt_q;
                phase_d = PH_MERGE_PREV;
              end else if (hit_d != '0 && pp_q.kind == KIND_FREE) begin
                k_d = hit_d; stop_d = cnt_q - 1'b1; phase_d = PH_NONE;
                st_d = S_SLR;
              end else begin
                st_d = S_FIN;
              end
            end
          end else if (idx_q >= cnt_q) begin
            rsp_d.status = ST_INVALID_FREE; st_d = S_FIN;
          end else begin
            prev_d = rdata; idx_d = idx_q + 1'b1; pp_d = prev_q;
            raddr = idx_d[IdxW-1:0]; st_d = S_CHK;
          end
        end
      end
      S_SHR: begin
        if (k_q == stop_q) begin
          we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = ins_q;
          cnt_d = cnt_q + 1'b1; st_d = S_FIN;
        end else begin
          raddr = IdxW'(k_q - 1'b1); st_d = S_SHW;
        end
      end
      S_SHW: begin
        we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = rdata;
        k_d = k_q - 1'b1; st_d = S_SHR;
      end
      S_SLR: begin
        if (k_q >= stop_q) begin
          cnt_d = cnt_q - 1'b1;
          if (phase_q == PH_MERGE_PREV && hit_q != '0 && pp_q.kind == KIND_FREE) begin
            phase_d = PH_NONE; k_d = hit_q; stop_d = cnt_d - 1'b1;
            st_d = S_SLR;
          end else begin
            st_d = S_FIN;
          end
        end else begin
          raddr = IdxW'(k_q + 1'b1); st_d = S_SLW;
        end
      end
      S_SLW: begin
        we = 1'b1; waddr = k_q[IdxW-1:0]; wdata = rdata;
        k_d = k_q + 1'b1; st_d = S_SLR;
      end
      S_FIN: begin
        if (rsp_q.status != ST_OK) rsp_d.address = '0;
        done_d = 1'b1; st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; done_q <= 1'b0; phase_q <= PH_NONE;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_q <= done_d; phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; k_q <= k_d; stop_q <= stop_d; hit_q <= hit_d;
    prev_q <= (st_q == S_IDLE) ? '{word: '0, kind: KIND_NONE} : prev_d;
    pp_q <= (st_q == S_IDLE) ? '{word: '0, kind: KIND_NONE} : pp_d;
    ins_q <= ins_d; cmd_q <= cmd_d; rsp_q <= rsp_d;
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxEntries)) else $error("entry count overflow");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("double result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> st_q != S_IDLE) else $error("pop without work");
`endif

endmodule
